@@ sv/lpe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Legendre polynomial evaluator package
// Shared widths, fixed-point constants, the token passed along the cell chain,
// the controller and cell sequencer states, and the rounding helpers.
// ----------------------------------------------------------------------------
package lpe_pkg;

	localparam int DEG_W     = 6;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 64;
	localparam int FRAC_BITS = 30;
	localparam int COEF_BITS = 30;

	localparam logic signed [DATA_W-1:0] ONE      = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0] ONE_WIDE = PROD_W'(64'd1 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0] HALF_FRAC = PROD_W'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [PROD_W-1:0] HALF_COEF = PROD_W'(64'd1 << (COEF_BITS - 1));
	localparam logic signed [DATA_W-1:0] POS_FULL = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic signed [DATA_W-1:0] NEG_FULL = {1'b1, {(DATA_W - 1){1'b0}}};

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] prev;
		logic signed [DATA_W-1:0] cur;
		logic [DEG_W-1:0]         remaining;
	} lpe_tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN
	} lpe_state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_XC,
		PH_BP,
		PH_AT,
		PH_DIFF,
		PH_ROUND
	} lpe_phase_t;

	// Divide by 2^FRAC_BITS, rounding to nearest with halves away from zero.
	function automatic logic signed [PROD_W-1:0] round_frac(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] bias;
		bias = v[PROD_W-1] ? (HALF_FRAC - PROD_W'(1)) : HALF_FRAC;
		return (v + bias) >>> FRAC_BITS;
	endfunction

	// Divide by 2^COEF_BITS, rounding to nearest with halves away from zero.
	function automatic logic signed [PROD_W-1:0] round_coef(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] bias;
		bias = v[PROD_W-1] ? (HALF_COEF - PROD_W'(1)) : HALF_COEF;
		return (v + bias) >>> COEF_BITS;
	endfunction

	// Clamp to [-1.0, +1.0]; this only absorbs rounding error.
	function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [PROD_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > ONE_WIDE) begin
			r = ONE;
		end else if (v < -ONE_WIDE) begin
			r = -ONE;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/lpe_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Legendre recurrence cell
// Performs one Bonnet step for a fixed index with a single shared multiplier,
// stepping through the XC, BP, AT, DIFF and ROUND phases before handing the
// item on, or passes the item on in the next cycle when no steps remain.
// ----------------------------------------------------------------------------
module lpe_cell
	import lpe_pkg::*;
#(
	parameter int STEP = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lpe_tok_t tok_in,
	output lpe_tok_t      tok_out
);

	localparam logic [63:0] A_NUM  = (64'(2 * STEP - 1) << COEF_BITS) + 64'(STEP / 2);
	localparam logic [63:0] B_NUM  = (64'(STEP - 1) << COEF_BITS) + 64'(STEP / 2);
	localparam logic [63:0] A_WIDE = A_NUM / 64'(STEP);
	localparam logic [63:0] B_WIDE = B_NUM / 64'(STEP);
	localparam logic [DATA_W-1:0] COEF_A = A_WIDE[DATA_W-1:0];
	localparam logic [DATA_W-1:0] COEF_B = B_WIDE[DATA_W-1:0];

	lpe_phase_t phase_q, phase_d;

	logic signed [DATA_W-1:0]   x_q, prev_q, cur_q, t_q;
	logic [DEG_W-1:0]           rem_q;
	logic signed [PROD_W-1:0]   m_q, bp_q, diff_q;
	logic signed [DATA_W:0]     op_a, op_b;
	logic signed [2*DATA_W+1:0] prod;
	logic signed [PROD_W-1:0]   prod_lo, t_round;
	logic signed [DATA_W-1:0]   next_val;
	logic                       pass_en, emit_en;

	logic                       out_valid_q;
	logic signed [DATA_W-1:0]   out_x_q, out_prev_q, out_cur_q;
	logic [DEG_W-1:0]           out_rem_q;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (tok_in.valid && (tok_in.remaining != '0)) begin
					phase_d = PH_XC;
				end
			end
			PH_XC:    phase_d = PH_BP;
			PH_BP:    phase_d = PH_AT;
			PH_AT:    phase_d = PH_DIFF;
			PH_DIFF:  phase_d = PH_ROUND;
			PH_ROUND: phase_d = PH_IDLE;
			default:  phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		pass_en = 1'b0;
		emit_en = 1'b0;
		op_a    = '0;
		op_b    = '0;
		unique case (phase_q)
			PH_IDLE: begin
				pass_en = tok_in.valid && (tok_in.remaining == '0);
			end
			PH_XC: begin
				op_a = {x_q[DATA_W-1], x_q};
				op_b = {cur_q[DATA_W-1], cur_q};
			end
			PH_BP: begin
				op_a = {1'b0, COEF_B};
				op_b = {prev_q[DATA_W-1], prev_q};
			end
			PH_AT: begin
				op_a = {1'b0, COEF_A};
				op_b = {t_q[DATA_W-1], t_q};
			end
			PH_ROUND: begin
				emit_en = 1'b1;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign prod     = op_a * op_b;
	assign prod_lo  = prod[PROD_W-1:0];
	assign t_round  = round_frac(m_q);
	assign next_val = clamp_unit(round_coef(diff_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			out_valid_q <= pass_en || emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if ((phase_q == PH_IDLE) && tok_in.valid) begin
			x_q    <= tok_in.x;
			prev_q <= tok_in.prev;
			cur_q  <= tok_in.cur;
			rem_q  <= tok_in.remaining;
		end
		if ((phase_q == PH_XC) || (phase_q == PH_AT)) begin
			m_q <= prod_lo;
		end
		if (phase_q == PH_BP) begin
			t_q  <= t_round[DATA_W-1:0];
			bp_q <= prod_lo;
		end
		if (phase_q == PH_DIFF) begin
			diff_q <= m_q - bp_q;
		end
		if (pass_en) begin
			out_x_q    <= tok_in.x;
			out_prev_q <= tok_in.prev;
			out_cur_q  <= tok_in.cur;
			out_rem_q  <= tok_in.remaining;
		end else if (emit_en) begin
			out_x_q    <= x_q;
			out_prev_q <= cur_q;
			out_cur_q  <= next_val;
			out_rem_q  <= rem_q - DEG_W'(1);
		end
	end

	always_comb begin
		tok_out.valid     = out_valid_q;
		tok_out.x         = out_x_q;
		tok_out.prev      = out_prev_q;
		tok_out.cur       = out_cur_q;
		tok_out.remaining = out_rem_q;
	end

endmodule
`default_nettype wire

@@ sv/legendre_polynomial_eval_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Legendre polynomial evaluator
// For degree zero or an argument outside [-1, 1] the result is set in the
// check state and done follows; else the item runs through the chain of
// MAX_DEGREE - 1 cells, the degree being clamped to MAX_DEGREE. A cell that
// has a step to do holds the item while its one multiplier works through the
// step, and an unused cell only registers it.
// One item at a time; busy is high from acceptance until done, and a new item
// may be accepted in the cycle of done. Reset clears the controller and the
// chain; results cannot be stalled.
// ----------------------------------------------------------------------------
module legendre_polynomial_eval_top
	import lpe_pkg::*;
#(
	parameter int MAX_DEGREE = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [DEG_W-1:0]         degree,
	input  wire logic signed [DATA_W-1:0] x_value,
	output logic                          done,
	output logic signed [DATA_W-1:0]      poly_value,
	output logic                          saturated
);

	localparam int CELLS = MAX_DEGREE - 1;

	lpe_state_t state_q, state_d;

	logic [DEG_W-1:0]         deg_q, deg_clamped;
	logic signed [DATA_W-1:0] x_q;
	logic                     accept, is_zero, x_over, x_under, special;
	logic                     finish_special, finish_chain;
	logic                     done_q, sat_q;
	logic signed [DATA_W-1:0] poly_q, special_val;

	lpe_tok_t chain [0:CELLS];

	assign deg_clamped = (int'(degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : degree;
	assign accept      = start && (state_q == ST_IDLE);

	assign is_zero = (deg_q == '0);
	assign x_over  = (x_q > ONE);
	assign x_under = (x_q < -ONE);
	assign special = is_zero || x_over || x_under;

	always_comb begin
		if (is_zero) begin
			special_val = ONE;
		end else if (x_over) begin
			special_val = POS_FULL;
		end else begin
			special_val = deg_q[0] ? NEG_FULL : POS_FULL;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = special ? ST_IDLE : ST_RUN;
			ST_RUN: begin
				if (chain[CELLS].valid) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy           = 1'b1;
		finish_special = 1'b0;
		finish_chain   = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_CHECK: finish_special = special;
			ST_RUN:   finish_chain = chain[CELLS].valid;
			default:  busy = 1'b1;
		endcase
	end

	always_comb begin
		chain[0].valid     = (state_q == ST_CHECK) && !special;
		chain[0].x         = x_q;
		chain[0].prev      = ONE;
		chain[0].cur       = x_q;
		chain[0].remaining = deg_q - DEG_W'(1);
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		lpe_cell #(
			.STEP(i + 2)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish_special || finish_chain;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deg_q <= deg_clamped;
			x_q   <= x_value;
		end
		if (finish_special) begin
			poly_q <= special_val;
			sat_q  <= !is_zero;
		end else if (finish_chain) begin
			poly_q <= chain[CELLS].cur;
			sat_q  <= 1'b0;
		end
	end

	assign done       = done_q;
	assign poly_value = poly_q;
	assign saturated  = sat_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result was marked while the block was still busy.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("Accepted item did not keep the block busy.");

	a_chain_run: assert property (@(posedge clk) disable iff (!arst_n)
		chain[CELLS].valid |-> (state_q == ST_RUN))
		else $error("Cell chain delivered an item outside a run.");

	a_sat_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> ((poly_value == POS_FULL) || (poly_value == NEG_FULL)))
		else $error("Saturated result is not a full-scale code.");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !saturated) |-> ((poly_value <= ONE) && (poly_value >= -ONE)))
		else $error("Unsaturated result lies outside the unit range.");

endmodule
`default_nettype wire
